// ===== rtl/upd_pkg.sv =====
package upd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // escape phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       string_done;
  } out_word_t;

  // one input word's worth of output bytes, bytes[0] goes out first
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            done;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

endpackage

// ===== rtl/upd_front.sv =====
module upd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  upd_pkg::in_word_t word,
  output upd_pkg::job_t   job,
  output logic            job_push
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] b;
  logic       last;
  logic       p_emit;
  logic [7:0] p_byte;

  assign b    = word.in_byte;
  assign last = word.end_of_string;

  // plain handling: a '%' opens an escape unless it is the final word
  assign p_emit = !(b == upd_pkg::CH_PERCENT && !last);
  assign p_byte = (b == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : b;

  always_comb begin
    job       = '0;
    job.done  = last;
    phase_nxt = p_emit ? upd_pkg::PH_IDLE : upd_pkg::PH_PCT;
    held_nxt  = held_r;
    case (phase_r)
      upd_pkg::PH_PCT: begin
        if (upd_pkg::is_hex(b) && !last) begin
          held_nxt  = b;
          phase_nxt = upd_pkg::PH_DIGIT;
        end else begin
          job.cnt      = p_emit ? 2'd2 : 2'd1;
          job.bytes[0] = upd_pkg::CH_PERCENT;
          job.bytes[1] = p_byte;
        end
      end
      upd_pkg::PH_DIGIT: begin
        held_nxt = 8'h00;
        if (upd_pkg::is_hex(b) && upd_pkg::is_hex(held_r)) begin
          job.cnt      = 2'd1;
          job.bytes[0] = {upd_pkg::hex_val(held_r), upd_pkg::hex_val(b)};
          phase_nxt    = upd_pkg::PH_IDLE;
        end else begin
          job.cnt      = p_emit ? 2'd3 : 2'd2;
          job.bytes[0] = upd_pkg::CH_PERCENT;
          job.bytes[1] = held_r;
          job.bytes[2] = p_byte;
        end
      end
      default: begin
        job.cnt      = p_emit ? 2'd1 : 2'd0;
        job.bytes[0] = p_byte;
      end
    endcase
    // the final word always returns to reset state
    if (last) begin
      phase_nxt = upd_pkg::PH_IDLE;
      held_nxt  = 8'h00;
    end
  end

  assign job_push = acc && (job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upd_pkg::PH_IDLE;
      held_r  <= 8'h00;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== rtl/upd_queue.sv =====
module upd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  upd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output upd_pkg::job_t q_job
);

  upd_pkg::job_t                    mem_r [upd_pkg::QUEUE_DEPTH];
  logic [upd_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [upd_pkg::QCNT_W-1:0]       cnt_r;

  assign full    = (cnt_r == upd_pkg::QCNT_W'(upd_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/upd_back.sv =====
module upd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  upd_pkg::job_t      q_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output upd_pkg::out_word_t out_data
);

  logic               cur_v_r;
  upd_pkg::job_t      cur_r;
  logic               out_valid_r;
  upd_pkg::out_word_t out_r;
  logic               adv;
  logic               cur_last;

  assign adv      = !out_valid_r || !out_stall;
  assign cur_last = (cur_r.cnt == 2'd1);
  assign pop      = q_valid && (!cur_v_r || (adv && cur_last));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) out_valid_r <= cur_v_r;
      if (pop) begin
        cur_v_r <= 1'b1;
      end else if (adv && cur_v_r && cur_last) begin
        cur_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cur_v_r) begin
      out_r.out_byte    <= cur_r.bytes[0];
      out_r.string_done <= cur_last && cur_r.done;
    end
    if (pop) begin
      cur_r <= q_job;
    end else if (adv && cur_v_r) begin
      // advance to the next pending byte
      cur_r.cnt   <= cur_r.cnt - 2'd1;
      cur_r.bytes <= {8'h00, cur_r.bytes[2:1]};
    end
  end

endmodule

// ===== rtl/url_percent_decoder_unit.sv =====
// URL percent decoder.
// Input channel (in_valid / in_stall / in_data): one encoded byte per word,
// with end_of_string set on the last byte of a string. Output channel
// (out_valid / out_stall / out_data): one decoded byte per word, with
// string_done set on the final decoded byte of the string.
// '+' decodes to a space, '%' plus two hex digits to the byte they give;
// a broken escape is emitted literally and the following bytes reprocessed.
// Each input word yields zero to three output words.
// A byte accepted on the input passes through the job queue, the current-job
// register and the output register to out_data. Throughput: one input word
// per cycle while each yields at most one output byte and out_stall is low;
// the output register emits one byte per cycle, so a word of two or three
// bytes holds it for each byte; the two-entry job queue absorbs short bursts.
// in_stall rises when the job queue is full.
// Reset (rst_n low, synchronous) clears the escape state, the queue and the
// output valid. A stall on out_stall holds out_data steady; the queue fills
// behind it and then stalls the input side.
module url_percent_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  upd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output upd_pkg::out_word_t out_data
);

  logic          acc;
  logic          push;
  logic          full;
  logic          pop;
  logic          q_valid;
  upd_pkg::job_t job;
  upd_pkg::job_t q_job;

  // take a word whenever the queue has room
  assign in_stall = full;
  assign acc      = in_valid && !full;

  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .word     (in_data),
    .job      (job),
    .job_push (push)
  );

  upd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
